@@ hdl/stq_pkg.sv @@
// shared types and constants of the serial tone queue player
package stq_pkg;

  localparam int unsigned CLK_HZ_W   = 20;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned DIV_OUT_W  = 8;
  localparam int unsigned DIV_STEPS  = 20;
  localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_CR   = 8'h0D;

  localparam logic [CLK_HZ_W-1:0] TONE_CLOCK_RESET = 20'd15625;
  localparam logic [DUR_W-1:0]    DURATION_RESET   = 16'd1953;

  // configuration register indexes
  localparam logic CFG_TONE_CLOCK = 1'b0;
  localparam logic CFG_DURATION   = 1'b1;

  typedef logic [4:0] queued_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic pop;
    logic set_div;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic start_req;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

@@ hdl/serial_tone_queue_player_top.sv @@
// serial tone queue player: top level
//
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// input    | in_valid / in_stall  | mode, rx_byte
// output   | out_valid / out_stall| playing, tone_divider, tone_frequency,
//          |                      | tone_started, entry_dropped, queued
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// an item that starts no tone goes from acceptance straight to ST_EMIT, where its result is loaded
// an item that starts a tone passes ST_READ and ST_LOAD to read and pop the queue, ST_DIV for
// the 20 divide steps and to take the quotient, and ST_EMIT to load the result
// one item is in flight at a time; in_stall is high from acceptance until the result is
// loaded into the output register, which waits while out_stall holds an older result
// reset is synchronous; the tone queue needs no clearing pass
module serial_tone_queue_player_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          playing,
  output logic [stq_pkg::DIV_OUT_W-1:0] tone_divider,
  output logic [stq_pkg::FREQ_W-1:0]    tone_frequency,
  output logic                          tone_started,
  output logic                          entry_dropped,
  output stq_pkg::queued_t              queued,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [stq_pkg::CLK_HZ_W-1:0]  cfg_data
);

  stq_pkg::cmd_t cmd;
  stq_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  stq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  stq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .rx_byte       (rx_byte),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .playing       (playing),
    .tone_divider  (tone_divider),
    .tone_frequency(tone_frequency),
    .tone_started  (tone_started),
    .entry_dropped (entry_dropped),
    .queued        (queued)
  );

endmodule

@@ hdl/stq_ram.sv @@
// generic single write port ram with registered read
module stq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/stq_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module stq_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [stq_pkg::CLK_HZ_W-1:0]  num,
  input  logic [stq_pkg::FREQ_W-1:0]    den,
  output logic                          done,
  output logic [stq_pkg::CLK_HZ_W-1:0]  quot
);

  logic                            busy;
  logic [stq_pkg::STEP_CNT_W-1:0]  cnt;
  logic [stq_pkg::FREQ_W-1:0]      rem;
  logic [stq_pkg::FREQ_W:0]        trial;
  logic [stq_pkg::FREQ_W+1:0]      diff;

  assign trial = {rem, quot[stq_pkg::CLK_HZ_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == stq_pkg::STEP_CNT_W'(stq_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // for a nonzero den the remainder stays below den, so it fits the denominator width
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
    end else if (busy) begin
      if (diff[stq_pkg::FREQ_W+1]) begin
        rem <= trial[stq_pkg::FREQ_W-1:0];
      end else begin
        rem <= diff[stq_pkg::FREQ_W-1:0];
      end
      quot <= {quot[stq_pkg::CLK_HZ_W-2:0], ~diff[stq_pkg::FREQ_W+1]};
    end
  end

endmodule

@@ hdl/stq_ctrl.sv @@
// sequencer for item acceptance, queue pop, divide and result hand-off
module stq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  stq_pkg::sts_t  sts,
  output stq_pkg::cmd_t  cmd
);

  stq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      stq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.start_req ? stq_pkg::ST_READ : stq_pkg::ST_EMIT;
        end
      end
      stq_pkg::ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = stq_pkg::ST_LOAD;
      end
      stq_pkg::ST_LOAD: begin
        cmd.pop    = 1'b1;
        state_next = stq_pkg::ST_DIV;
      end
      stq_pkg::ST_DIV: begin
        if (sts.div_done) begin
          cmd.set_div = 1'b1;
          state_next  = stq_pkg::ST_EMIT;
        end
      end
      stq_pkg::ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = stq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/stq_datapath.sv @@
// digit parsing, tone queue, tick timing, divider and result register
module stq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  stq_pkg::cmd_t                 cmd,
  output stq_pkg::sts_t                 sts,
  input  logic                          mode,
  input  logic [7:0]                    rx_byte,
  input  logic                          cfg_valid,
  input  logic                          cfg_index,
  input  logic [stq_pkg::CLK_HZ_W-1:0]  cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          playing,
  output logic [stq_pkg::DIV_OUT_W-1:0] tone_divider,
  output logic [stq_pkg::FREQ_W-1:0]    tone_frequency,
  output logic                          tone_started,
  output logic                          entry_dropped,
  output stq_pkg::queued_t              queued
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [stq_pkg::CLK_HZ_W-1:0]  tone_clock_hz;
  logic [stq_pkg::DUR_W-1:0]     duration_ticks;
  logic [stq_pkg::FREQ_W-1:0]    acc;
  logic [PTR_W-1:0]              rd_ptr;
  logic [PTR_W-1:0]              wr_ptr;
  logic [CNT_W-1:0]              count;
  logic                          sounding;
  logic [stq_pkg::DUR_W-1:0]     elapsed;
  logic [stq_pkg::DIV_OUT_W-1:0] cur_div;
  logic [stq_pkg::FREQ_W-1:0]    cur_freq;
  logic                          started;
  logic                          dropped;

  logic                          is_digit;
  logic                          is_cr;
  logic                          is_tick;
  logic                          full;
  logic                          push;
  logic [stq_pkg::DUR_W-1:0]     elapsed_inc;
  logic                          tone_end;
  logic [stq_pkg::FREQ_W-1:0]    acc_digit;
  logic [stq_pkg::FREQ_W-1:0]    ram_rdata;
  logic                          div_done;
  logic [stq_pkg::CLK_HZ_W-1:0]  div_quot;
  logic [stq_pkg::CLK_HZ_W-2:0]  half_quot;
  logic [stq_pkg::DIV_OUT_W-1:0] div_sat;

  assign is_tick  = mode;
  assign is_digit = !mode && (rx_byte >= stq_pkg::CHAR_ZERO) && (rx_byte <= stq_pkg::CHAR_NINE);
  assign is_cr    = !mode && (rx_byte == stq_pkg::CHAR_CR);
  assign full     = (count == CNT_FULL);
  assign push     = is_cr && !full;

  // acc * 10 + digit, wrapping at the accumulator width
  assign acc_digit = (acc << 3) + (acc << 1)
                   + stq_pkg::FREQ_W'(rx_byte[3:0]);

  assign elapsed_inc = (elapsed != '1) ? elapsed + 1'b1 : elapsed;
  assign tone_end    = is_tick && sounding && (elapsed_inc >= duration_ticks);

  assign sts.start_req = (is_cr && !sounding && (push || (count != '0)))
                       || (tone_end && (count != '0));
  assign sts.div_done  = div_done;
  assign sts.out_busy  = out_valid && out_stall;

  // divider value is half the quotient, saturated to 8 bits
  assign half_quot = div_quot[stq_pkg::CLK_HZ_W-1:1];
  assign div_sat   = (|half_quot[stq_pkg::CLK_HZ_W-2:stq_pkg::DIV_OUT_W])
                   ? '1 : half_quot[stq_pkg::DIV_OUT_W-1:0];

  stq_ram #(
    .WIDTH(stq_pkg::FREQ_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (cmd.accept && push),
    .waddr(wr_ptr),
    .wdata(acc),
    .re   (cmd.rd_en),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  // a zero frequency divides to all ones, which saturates as required
  stq_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.pop),
    .num  (tone_clock_hz),
    .den  (ram_rdata),
    .done (div_done),
    .quot (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_clock_hz  <= stq_pkg::TONE_CLOCK_RESET;
      duration_ticks <= stq_pkg::DURATION_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        stq_pkg::CFG_TONE_CLOCK: tone_clock_hz  <= cfg_data;
        stq_pkg::CFG_DURATION:   duration_ticks <= cfg_data[stq_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      count    <= '0;
      sounding <= 1'b0;
      elapsed  <= '0;
      cur_div  <= '0;
      cur_freq <= '0;
    end else begin
      if (cmd.accept) begin
        if (is_digit) begin
          acc <= acc_digit;
        end else if (!is_tick) begin
          acc <= '0;
        end
        if (push) begin
          wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
          count  <= count + 1'b1;
        end
        if (is_tick && sounding) begin
          elapsed <= elapsed_inc;
        end
        if (tone_end) begin
          sounding <= 1'b0;
          cur_freq <= '0;
          cur_div  <= '0;
          elapsed  <= '0;
        end
      end
      if (cmd.pop) begin
        rd_ptr   <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
        count    <= count - 1'b1;
        cur_freq <= ram_rdata;
        elapsed  <= '0;
        sounding <= 1'b1;
      end
      if (cmd.set_div) begin
        cur_div <= div_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      started <= sts.start_req;
      dropped <= is_cr && full;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      playing        <= sounding;
      tone_divider   <= cur_div;
      tone_frequency <= cur_freq;
      tone_started   <= started;
      entry_dropped  <= dropped;
      queued         <= stq_pkg::queued_t'(count);
    end
  end

endmodule

@@ hdl/stq_checker.sv @@
// port-level checks of the serial tone queue player and their bind
module stq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          playing,
  input logic [stq_pkg::DIV_OUT_W-1:0] tone_divider,
  input logic [stq_pkg::FREQ_W-1:0]    tone_frequency,
  input logic                          tone_started,
  input logic                          entry_dropped,
  input stq_pkg::queued_t              queued
);

  // a held result stays valid and keeps its tone frequency and queue count
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tone_frequency) && $stable(queued))
    else $error("stalled result changed");

  // one transaction in flight: the input side closes right after acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in flight");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !playing |-> tone_frequency == '0 && tone_divider == '0 && !tone_started)
    else $error("silent result carries tone data");

  a_start_plays: assert property (@(posedge clk) disable iff (rst)
    out_valid && tone_started |-> playing)
    else $error("tone started but not playing");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_dropped |-> queued == stq_pkg::queued_t'(QUEUE_DEPTH))
    else $error("entry dropped while queue not full");

endmodule

bind serial_tone_queue_player_top stq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_stq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .playing       (playing),
  .tone_divider  (tone_divider),
  .tone_frequency(tone_frequency),
  .tone_started  (tone_started),
  .entry_dropped (entry_dropped),
  .queued        (queued)
);
